// ===== rtl/plft_pkg.sv =====
// ----------------------------------------------------------------------------
// plft_pkg
// Shared beat types, command codes and microcode control types for the
// prefix Lyndon factor tail block.
// ----------------------------------------------------------------------------
package plft_pkg;

  // field widths fixed by the beat format
  localparam int IDX_W = 11;
  localparam int SYM_W = 8;
  localparam int CNT_W = 11;

  // command codes
  localparam logic [1:0] OP_APPEND  = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] index;
  } in_beat_t;

  typedef struct packed {
    logic [CNT_W-1:0] period_len;
    logic [CNT_W-1:0] repeat_count;
    logic             index_error;
    logic             overflow_seen;
  } out_beat_t;

  // microprogram step addresses
  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_INIT    = 3'd0;
  localparam step_t ST_OUTER   = 3'd1;
  localparam step_t ST_RD_LAG  = 3'd2;
  localparam step_t ST_RD_LEAD = 3'd3;
  localparam step_t ST_WRITE   = 3'd4;
  localparam step_t ST_DONE    = 3'd5;

  // jump conditions
  typedef enum logic [1:0] {
    COND_NEVER    = 2'd0,
    COND_SCAN_END = 2'd1,
    COND_RUN_END  = 2'd2
  } cond_e;

  // datapath register update selects
  typedef enum logic [1:0] {
    UPD_NONE    = 2'd0,
    UPD_CLEAR   = 2'd1,
    UPD_OPEN    = 2'd2,
    UPD_ADVANCE = 2'd3
  } upd_e;

  // table write data select
  typedef enum logic {
    WSEL_ZERO = 1'b0,
    WSEL_TAIL = 1'b1
  } wsel_e;

  // symbol read address select
  typedef enum logic {
    ASEL_LAG  = 1'b0,
    ASEL_LEAD = 1'b1
  } asel_e;

  // control word driven into the datapath
  typedef struct packed {
    logic  tbl_we;
    wsel_e wsel;
    logic  tbl_re;
    logic  sym_re;
    asel_e asel;
    logic  cap_lag;
    upd_e  upd;
    logic  last;
  } ctrl_t;

  // full microcode word
  typedef struct packed {
    cond_e cond;
    step_t jmp;
    step_t nxt;
    ctrl_t ctl;
  } ucw_t;

  // status flags back from the datapath
  typedef struct packed {
    logic scan_end;
    logic run_end;
  } flags_t;

endpackage

// ===== rtl/plft_ram.sv =====
// ----------------------------------------------------------------------------
// plft_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module plft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/plft_useq.sv =====
// ----------------------------------------------------------------------------
// plft_useq
// Microcode sequencer: step counter, control store and conditional jumps
// that run one factorization pass over the loaded string.
// ----------------------------------------------------------------------------
module plft_useq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  plft_pkg::flags_t flags_i,
  output plft_pkg::ctrl_t  ctl_o,
  output logic             busy_o
);
  import plft_pkg::*;

  // control store
  function automatic ucw_t ucode_rom(input step_t step);
    ucw_t w;
    w = '0;
    w.cond = COND_NEVER;
    case (step)
      ST_INIT: begin
        // entry 0 is (0,0), first run opens at position 0
        w.ctl.tbl_we = 1'b1;
        w.ctl.wsel   = WSEL_ZERO;
        w.ctl.upd    = UPD_CLEAR;
        w.nxt        = ST_OUTER;
      end
      ST_OUTER: begin
        w.ctl.upd = UPD_OPEN;
        w.cond    = COND_SCAN_END;
        w.jmp     = ST_DONE;
        w.nxt     = ST_RD_LAG;
      end
      ST_RD_LAG: begin
        w.ctl.sym_re = 1'b1;
        w.ctl.asel   = ASEL_LAG;
        w.ctl.tbl_re = 1'b1;
        w.nxt        = ST_RD_LEAD;
      end
      ST_RD_LEAD: begin
        w.ctl.cap_lag = 1'b1;
        w.ctl.sym_re  = 1'b1;
        w.ctl.asel    = ASEL_LEAD;
        w.nxt         = ST_WRITE;
      end
      ST_WRITE: begin
        w.ctl.tbl_we = 1'b1;
        w.ctl.wsel   = WSEL_TAIL;
        w.ctl.upd    = UPD_ADVANCE;
        w.cond       = COND_RUN_END;
        w.jmp        = ST_OUTER;
        w.nxt        = ST_RD_LAG;
      end
      ST_DONE: begin
        w.ctl.last = 1'b1;
        w.nxt      = ST_INIT;
      end
      default: begin
        w.ctl.last = 1'b1;
        w.nxt      = ST_INIT;
      end
    endcase
    return w;
  endfunction

  logic  busy_q, busy_d;
  step_t step_q, step_d;
  ucw_t  word;
  logic  take;

  assign word = ucode_rom(step_q);

  // jump condition select
  always_comb begin
    case (word.cond)
      COND_SCAN_END: take = flags_i.scan_end;
      COND_RUN_END:  take = flags_i.run_end;
      default:       take = 1'b0;
    endcase
  end

  // step counter
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (busy_q) begin
      step_d = take ? word.jmp : word.nxt;
      if (word.ctl.last) begin
        busy_d = 1'b0;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      step_d = ST_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= ST_INIT;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  assign ctl_o  = busy_q ? word.ctl : '0;
  assign busy_o = busy_q;

endmodule

// ===== rtl/plft_dp.sv =====
// ----------------------------------------------------------------------------
// plft_dp
// Scan datapath: run start, period, repeat, remainder and position
// registers, symbol compare and table write data.
// ----------------------------------------------------------------------------
module plft_dp #(
  parameter int LW = 11,
  parameter int AW = 10,
  parameter int SB = 8
) (
  input  logic             clk_i,
  input  plft_pkg::ctrl_t  ctl_i,
  input  logic [LW-1:0]    len_i,
  input  logic [SB-1:0]    sym_rdata_i,
  output logic             sym_re_o,
  output logic [AW-1:0]    sym_raddr_o,
  input  logic [2*LW-1:0]  tbl_rdata_i,
  output logic             tbl_re_o,
  output logic [LW-1:0]    tbl_raddr_o,
  output logic             tbl_we_o,
  output logic [LW-1:0]    tbl_waddr_o,
  output logic [2*LW-1:0]  tbl_wdata_o,
  output plft_pkg::flags_t flags_o
);
  import plft_pkg::*;

  logic [LW-1:0] start_q, start_d;
  logic [LW-1:0] per_q, per_d;
  logic [LW-1:0] rep_q, rep_d;
  logic [LW-1:0] rem_q, rem_d;
  logic [LW-1:0] pos_q, pos_d;
  logic [SB-1:0] lag_q;
  logic [LW-1:0] rem_inc;
  logic [LW-1:0] lag_addr;
  logic          run_end;

  // symbol and table read addresses
  assign lag_addr    = pos_q - per_q;
  assign sym_re_o    = ctl_i.sym_re;
  assign sym_raddr_o = (ctl_i.asel == ASEL_LAG) ? lag_addr[AW-1:0] : pos_q[AW-1:0];
  assign tbl_re_o    = ctl_i.tbl_re;
  assign tbl_raddr_o = start_q + rem_q;

  // table write: inside a repeat, copy the entry at the same offset in the run's first period
  assign tbl_we_o = ctl_i.tbl_we;
  always_comb begin
    if (ctl_i.wsel == WSEL_ZERO) begin
      tbl_waddr_o = '0;
      tbl_wdata_o = '0;
    end else begin
      tbl_waddr_o = pos_q;
      tbl_wdata_o = (rem_q != '0) ? tbl_rdata_i : {per_q, rep_q};
    end
  end

  // run ends at the string end or on a descent
  assign run_end = (pos_q == len_i) || (lag_q > sym_rdata_i);
  assign flags_o.run_end  = run_end;
  assign flags_o.scan_end = (start_q >= len_i);

  assign rem_inc = rem_q + 1'b1;

  // register updates
  always_comb begin
    start_d = start_q;
    per_d   = per_q;
    rep_d   = rep_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    case (ctl_i.upd)
      UPD_CLEAR: begin
        start_d = '0;
      end
      UPD_OPEN: begin
        per_d = LW'(1);
        rep_d = LW'(1);
        rem_d = '0;
        pos_d = start_q + 1'b1;
      end
      UPD_ADVANCE: begin
        if (run_end) begin
          start_d = pos_q - rem_q;
        end else if (lag_q < sym_rdata_i) begin
          per_d = pos_q + 1'b1 - start_q;
          rep_d = LW'(1);
          rem_d = '0;
          pos_d = pos_q + 1'b1;
        end else begin
          if (rem_inc == per_q) begin
            rep_d = rep_q + 1'b1;
            rem_d = '0;
          end else begin
            rem_d = rem_inc;
          end
          pos_d = pos_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    per_q   <= per_d;
    rep_q   <= rep_d;
    rem_q   <= rem_d;
    pos_q   <= pos_d;
    if (ctl_i.cap_lag) begin
      lag_q <= sym_rdata_i;
    end
  end

endmodule

// ===== rtl/prefix_lyndon_factor_tail.sv =====
// ----------------------------------------------------------------------------
// prefix_lyndon_factor_tail
// Loads a symbol string, computes the last Lyndon factor length and its
// repeat count for every prefix, and answers queries per prefix length.
// ----------------------------------------------------------------------------
// A query beat reads the table into its read register, and its answer is
// then loaded into the output register. A compute beat runs a microcoded
// pass bound by the symbol memory's single read port: each scanned position
// reads the lagging symbol, then the leading one, then writes its table
// entry. Beats are stalled during the pass. Symbols compare as unsigned
// values; appends past MAX_LEN are dropped and set a sticky overflow bit.
// Memories need no clearing pass.
module prefix_lyndon_factor_tail #(
  parameter int MAX_LEN     = 1024,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  plft_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output plft_pkg::out_beat_t out_beat_o
);
  import plft_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = (LW > IDX_W) ? LW : IDX_W;

  logic          busy;
  ctrl_t         ctl;
  flags_t        flags;
  logic          in_acc;
  logic          acc_append, acc_compute, acc_query;
  logic [LW-1:0] len_q, len_d;
  logic          ovf_q, ovf_d;
  logic          ready_q, ready_d;
  logic          qry_pend_q;
  logic          qry_err_q;
  logic          out_valid_q, out_valid_d;
  out_beat_t     out_q;
  logic [CW-1:0] idx_ext;
  logic          full;

  logic             sym_we;
  logic [SYMBOL_BITS-1:0] sym_wdata;
  logic             sym_re;
  logic [AW-1:0]    sym_raddr;
  logic [SYMBOL_BITS-1:0] sym_rdata;

  logic             dp_tbl_re;
  logic [LW-1:0]    dp_tbl_raddr;
  logic             tbl_re;
  logic [LW-1:0]    tbl_raddr;
  logic             tbl_we;
  logic [LW-1:0]    tbl_waddr;
  logic [2*LW-1:0]  tbl_wdata;
  logic [2*LW-1:0]  tbl_rdata;

  // input handshake
  assign in_stall_o  = busy | qry_pend_q | (out_valid_q & out_stall_i);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign acc_append  = in_acc && (in_beat_i.op == OP_APPEND);
  assign acc_compute = in_acc && (in_beat_i.op == OP_COMPUTE);
  assign acc_query   = in_acc && (in_beat_i.op == OP_QUERY);

  assign full      = (len_q == LW'(MAX_LEN));
  assign idx_ext   = CW'(in_beat_i.index);
  assign sym_we    = acc_append & ~full;
  assign sym_wdata = SYMBOL_BITS'(in_beat_i.symbol);

  // string length, overflow and ready flags
  always_comb begin
    len_d   = len_q;
    ovf_d   = ovf_q;
    ready_d = ready_q;
    if (acc_append) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        len_d   = len_q + 1'b1;
        ready_d = 1'b0;
      end
    end
    if (ctl.last) begin
      ready_d = 1'b1;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (qry_pend_q) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      ready_q     <= 1'b0;
      qry_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      ready_q     <= ready_d;
      qry_pend_q  <= acc_query;
      out_valid_q <= out_valid_d;
    end
  end

  // query payload
  always_ff @(posedge clk_i) begin
    if (acc_query) begin
      qry_err_q <= !ready_q || (idx_ext > CW'(len_q));
    end
    if (qry_pend_q) begin
      out_q.period_len    <= qry_err_q ? '0 : CNT_W'(tbl_rdata[2*LW-1:LW]);
      out_q.repeat_count  <= qry_err_q ? '0 : CNT_W'(tbl_rdata[LW-1:0]);
      out_q.index_error   <= qry_err_q;
      out_q.overflow_seen <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // table read port shared between the pass and queries
  assign tbl_re    = dp_tbl_re | acc_query;
  assign tbl_raddr = busy ? dp_tbl_raddr : idx_ext[LW-1:0];

  plft_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acc_compute),
    .flags_i (flags),
    .ctl_o   (ctl),
    .busy_o  (busy)
  );

  plft_dp #(
    .LW (LW),
    .AW (AW),
    .SB (SYMBOL_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .len_i       (len_q),
    .sym_rdata_i (sym_rdata),
    .sym_re_o    (sym_re),
    .sym_raddr_o (sym_raddr),
    .tbl_rdata_i (tbl_rdata),
    .tbl_re_o    (dp_tbl_re),
    .tbl_raddr_o (dp_tbl_raddr),
    .tbl_we_o    (tbl_we),
    .tbl_waddr_o (tbl_waddr),
    .tbl_wdata_o (tbl_wdata),
    .flags_o     (flags)
  );

  // symbol store
  plft_ram #(
    .WIDTH (SYMBOL_BITS),
    .DEPTH (MAX_LEN)
  ) u_sym_ram (
    .clk_i   (clk_i),
    .we_i    (sym_we),
    .waddr_i (len_q[AW-1:0]),
    .wdata_i (sym_wdata),
    .re_i    (sym_re),
    .raddr_i (sym_raddr),
    .rdata_o (sym_rdata)
  );

  // period and repeat count table, one entry per prefix length
  plft_ram #(
    .WIDTH (2 * LW),
    .DEPTH (MAX_LEN + 1)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

endmodule

// ===== bench/prefix_lyndon_factor_tail_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_lyndon_factor_tail_test
// Self-checking bench for the prefix Lyndon factor tail block. A queue of
// append, compute and query beats feeds a valid/stall driver; every accepted
// beat updates a behavioral copy of the string and its per-prefix factor
// tables, and each query answer is compared field by field as it leaves.
// ----------------------------------------------------------------------------
module prefix_lyndon_factor_tail_test;
  import plft_pkg::*;

  localparam int         STORE_DEPTH = 1024;
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         IDLE_LIMIT  = 40000;
  localparam int         HOLD_CYCLES = 400;
  localparam int         END_PAUSE   = 50;

  typedef enum int {
    ALPHA_BINARY,
    ALPHA_MIDPOINT,
    ALPHA_EXTREMES,
    ALPHA_FULL
  } alphabet_e;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_stall = 1'b1;
  out_beat_t out_beat;

  // behavioral copy of the block state
  logic [SYM_W-1:0] sym_copy    [STORE_DEPTH+1];
  logic [CNT_W-1:0] tail_period [STORE_DEPTH+1];
  logic [CNT_W-1:0] tail_repeat [STORE_DEPTH+1];
  int unsigned      loaded_len   = 0;
  logic             dropped_seen = 1'b0;
  logic             tables_valid = 1'b0;

  in_beat_t    pending_beats [$];
  out_beat_t   tail_answers  [$];
  out_beat_t   want_beat;
  int unsigned plan_len       = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned n_in_beats = 0;
  int unsigned n_checked  = 0;
  int unsigned n_passes   = 0;
  int unsigned n_errors   = 0;

  logic        hold_go      = 1'b0;
  logic        hold_spent   = 1'b0;
  int unsigned hold_left    = 0;
  logic        fill_stalled = 1'b0;
  int unsigned quiet_cycles = 0;

  prefix_lyndon_factor_tail #(
    .MAX_LEN    (STORE_DEPTH),
    .SYMBOL_BITS(SYM_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // duval pass: last factor length and repeat count for every prefix
  function automatic void factor_prefixes();
    int unsigned n, start, per, rep, rem, pos;
    logic        scanning;
    n     = loaded_len;
    start = 0;
    tail_period[0] = '0;
    tail_repeat[0] = '0;
    while (start < n) begin
      per      = 1;
      rep      = 1;
      rem      = 0;
      pos      = start + 1;
      scanning = 1'b1;
      while (scanning) begin
        if (rem != 0) begin
          tail_period[pos] = tail_period[start + rem];
          tail_repeat[pos] = tail_repeat[start + rem];
        end else begin
          tail_period[pos] = per[CNT_W-1:0];
          tail_repeat[pos] = rep[CNT_W-1:0];
        end
        if (pos == n || sym_copy[pos - per] > sym_copy[pos]) begin
          start    = pos - rem;
          scanning = 1'b0;
        end else if (sym_copy[pos - per] < sym_copy[pos]) begin
          per = pos + 1 - start;
          rep = 1;
          rem = 0;
          pos++;
        end else begin
          rem++;
          if (rem == per) begin
            rep++;
            rem = 0;
          end
          pos++;
        end
      end
    end
  endfunction

  // apply one accepted beat to the copy, queue the answer of a query
  function automatic void track_beat(in_beat_t b);
    out_beat_t ans;
    ans = '0;
    case (b.op)
      OP_APPEND: begin
        if (loaded_len >= STORE_DEPTH) begin
          dropped_seen = 1'b1;
        end else begin
          sym_copy[loaded_len] = b.symbol;
          loaded_len++;
          tables_valid = 1'b0;
        end
      end
      OP_COMPUTE: begin
        factor_prefixes();
        tables_valid = 1'b1;
        n_passes++;
      end
      OP_QUERY: begin
        if (!tables_valid || b.index > loaded_len) begin
          ans.index_error = 1'b1;
        end else begin
          ans.period_len   = tail_period[b.index];
          ans.repeat_count = tail_repeat[b.index];
        end
        ans.overflow_seen = dropped_seen;
        tail_answers.push_back(ans);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (n_errors < 25) begin
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    end
    n_errors++;
  endtask

  function automatic void queue_beat(logic [1:0] op, logic [SYM_W-1:0] sym,
                                     logic [IDX_W-1:0] idx);
    in_beat_t b;
    b.op     = op;
    b.symbol = sym;
    b.index  = idx;
    pending_beats.push_back(b);
    if (op == OP_APPEND && plan_len < STORE_DEPTH) begin
      plan_len++;
    end
  endfunction

  function automatic logic [SYM_W-1:0] pick_symbol(alphabet_e alpha);
    case (alpha)
      ALPHA_BINARY:   return SYM_W'($urandom_range(1, 0));
      ALPHA_MIDPOINT: return SYM_W'(8'h7e + $urandom_range(3, 0));
      ALPHA_EXTREMES: return $urandom_range(1, 0) ? 8'hff : 8'h00;
      default:        return SYM_W'($urandom_range(255, 0));
    endcase
  endfunction

  // filler for fields that the op ignores
  function automatic logic [SYM_W-1:0] rand_symbol();
    return SYM_W'($urandom_range(255, 0));
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    return IDX_W'($urandom_range(2047, 0));
  endfunction

  // mostly reachable prefixes, some past the loaded length
  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(99, 0) < 15) begin
      return IDX_W'($urandom_range(2047, plan_len + 1));
    end
    return IDX_W'($urandom_range(plan_len, 0));
  endfunction

  // periodic word with an optional breaking tail, usually a pass, then read-back
  task automatic build_round(int unsigned target);
    logic [SYM_W-1:0] word [5];
    alphabet_e        alpha;
    int unsigned      wlen, reps;
    alpha = alphabet_e'($urandom_range(3, 0));
    wlen  = $urandom_range(5, 1);
    reps  = $urandom_range(4, 1);
    for (int i = 0; i < wlen; i++) word[i] = pick_symbol(alpha);
    for (int r = 0; r < reps; r++) begin
      for (int i = 0; i < wlen; i++) begin
        if (plan_len < target) queue_beat(OP_APPEND, word[i], rand_index());
      end
    end
    if ($urandom_range(1, 0) == 1 && plan_len < target) begin
      queue_beat(OP_APPEND, pick_symbol(alpha), rand_index());
    end
    if ($urandom_range(9, 0) == 0) begin
      queue_beat(OP_UNUSED, rand_symbol(), rand_index());
    end
    if ($urandom_range(9, 0) != 0) begin
      queue_beat(OP_COMPUTE, rand_symbol(), rand_index());
    end
    repeat ($urandom_range(10, 3)) begin
      queue_beat(OP_QUERY, rand_symbol(), pick_index());
    end
  endtask

  task automatic drain_pipeline();
    while (pending_beats.size() != 0 || in_valid || tail_answers.size() != 0) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_beat  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        track_beat(in_beat);
        n_in_beats++;
      end
      if (in_valid && in_stall && hold_left != 0) fill_stalled = 1'b1;
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_beat  <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off
  always @(posedge clk_i) begin
    if (hold_go && !hold_spent) begin
      hold_spent <= 1'b1;
      hold_left  <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (tail_answers.size() == 0) begin
          report_mismatch("result beat with nothing expected, period_len",
                          32'(out_beat.period_len), 0);
        end else begin
          want_beat = tail_answers.pop_front();
          if (out_beat.period_len !== want_beat.period_len)
            report_mismatch("period_len", 32'(out_beat.period_len),
                            32'(want_beat.period_len));
          if (out_beat.repeat_count !== want_beat.repeat_count)
            report_mismatch("repeat_count", 32'(out_beat.repeat_count),
                            32'(want_beat.repeat_count));
          if (out_beat.index_error !== want_beat.index_error)
            report_mismatch("index_error", 32'(out_beat.index_error),
                            32'(want_beat.index_error));
          if (out_beat.overflow_seen !== want_beat.overflow_seen)
            report_mismatch("overflow_seen", 32'(out_beat.overflow_seen),
                            32'(want_beat.overflow_seen));
          n_checked++;
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // watchdog on cycles without any beat moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("FAIL prefix_lyndon_factor_tail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    int unsigned target;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty tables, empty string, stale tables, range edges, unsigned order
    queue_beat(OP_QUERY, 8'h00, 11'd0);
    queue_beat(OP_COMPUTE, 8'hff, 11'h7ff);
    queue_beat(OP_QUERY, 8'hff, 11'd0);
    queue_beat(OP_QUERY, 8'h00, 11'd1);
    queue_beat(OP_UNUSED, 8'hff, 11'h7ff);
    queue_beat(OP_APPEND, 8'hff, 11'd0);
    queue_beat(OP_APPEND, 8'h00, 11'h7ff);
    queue_beat(OP_APPEND, 8'hff, 11'd0);
    queue_beat(OP_APPEND, 8'h00, 11'd0);
    queue_beat(OP_QUERY, 8'h00, 11'd1);
    queue_beat(OP_COMPUTE, 8'h00, 11'd0);
    for (int i = 0; i <= 5; i++) queue_beat(OP_QUERY, 8'h55, IDX_W'(i));
    queue_beat(OP_QUERY, 8'haa, 11'd1024);
    queue_beat(OP_QUERY, 8'h00, 11'h7ff);
    queue_beat(OP_APPEND, 8'h80, 11'h400);
    queue_beat(OP_APPEND, 8'h7f, 11'h3ff);
    queue_beat(OP_COMPUTE, 8'h00, 11'd0);
    queue_beat(OP_QUERY, 8'h00, 11'd6);
    queue_beat(OP_QUERY, 8'h00, 11'd5);
    drain_pipeline();

    // random rounds, string grows by a quarter of the store per idling mode
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 86;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 86;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase
      if (ph == 0) begin
        // burst of queries against a held output so the input backs up
        hold_go = 1'b1;
        repeat (40) queue_beat(OP_QUERY, rand_symbol(), pick_index());
      end
      target = (ph + 1) * STORE_DEPTH / 4;
      while (plan_len < target) build_round(target);
      if (ph == 3) begin
        // full store, dropped appends, tables stay readable
        queue_beat(OP_COMPUTE, rand_symbol(), rand_index());
        queue_beat(OP_QUERY, 8'h00, 11'd1024);
        queue_beat(OP_QUERY, 8'hff, 11'd1023);
        repeat (4) queue_beat(OP_APPEND, rand_symbol(), rand_index());
        queue_beat(OP_QUERY, 8'h00, 11'd1024);
        queue_beat(OP_QUERY, 8'h00, 11'd1025);
        repeat (6) queue_beat(OP_QUERY, rand_symbol(), pick_index());
        queue_beat(OP_COMPUTE, rand_symbol(), rand_index());
        repeat (6) queue_beat(OP_QUERY, rand_symbol(), pick_index());
      end
      drain_pipeline();
    end

    repeat (END_PAUSE) @(posedge clk_i);
    if (tail_answers.size() != 0) begin
      report_mismatch("answers still outstanding", tail_answers.size(), 0);
    end

    $display("run covered %0d input beats, %0d factor passes, string grew to %0d symbols",
             n_in_beats, n_passes, loaded_len);
    $display("%0d answers checked, overflow hit: %0b, input backed up under output hold: %0b",
             n_checked, dropped_seen, fill_stalled);
    if (n_errors == 0) begin
      $display("PASS prefix_lyndon_factor_tail");
    end else begin
      $display("FAIL prefix_lyndon_factor_tail");
    end
    $finish;
  end

endmodule
